// ===== hdl/nlp_pkg.sv =====
// nlp_pkg: phase, radix and status codes and the character helpers for the
// numeric literal parser. No dependencies.
package nlp_pkg;

  localparam int unsigned SymbolW = 8;
  localparam int unsigned NumberW = 64;
  localparam int unsigned RadixW  = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 3;

  typedef logic [SymbolW-1:0] symbol_t;
  typedef logic [NumberW-1:0] number_t;
  typedef logic [RadixW-1:0]  radix_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [PhaseW-1:0]  phase_t;

  localparam phase_t PH_START     = 3'd0;
  localparam phase_t PH_ZERO      = 3'd1;
  localparam phase_t PH_DEC       = 3'd2;
  localparam phase_t PH_HEX_EMPTY = 3'd3;
  localparam phase_t PH_HEX       = 3'd4;
  localparam phase_t PH_BIN_EMPTY = 3'd5;
  localparam phase_t PH_BIN       = 3'd6;
  localparam phase_t PH_BAD       = 3'd7;

  localparam radix_t RADIX_HEX = 2'd0;
  localparam radix_t RADIX_DEC = 2'd1;
  localparam radix_t RADIX_BIN = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD      = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  localparam symbol_t CH_0     = 8'd48;
  localparam symbol_t CH_1     = 8'd49;
  localparam symbol_t CH_9     = 8'd57;
  localparam symbol_t CH_LO_A  = 8'd97;
  localparam symbol_t CH_LO_F  = 8'd102;
  localparam symbol_t CH_UP_A  = 8'd65;
  localparam symbol_t CH_UP_F  = 8'd70;
  localparam symbol_t CH_LO_X  = 8'd120;
  localparam symbol_t CH_UP_X  = 8'd88;
  localparam symbol_t CH_LO_B  = 8'd98;
  localparam symbol_t CH_UP_B  = 8'd66;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t hex_digit(input symbol_t c);
    digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d.value = c[3:0];
    end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      // letters a..f and A..F share their low three bits: 1..6
      d.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_dec_digit(input symbol_t c);
    return (c >= CH_0 && c <= CH_9);
  endfunction

endpackage

// ===== hdl/nlp_in_if.sv =====
// nlp_in_if: valid/ready channel carrying one literal character per item.
// Depends on nlp_pkg.
interface nlp_in_if import nlp_pkg::*; ();
  logic    valid;
  logic    ready;
  symbol_t symbol;
  logic    is_final;

  modport source (output valid, output symbol, output is_final, input ready);
  modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

// ===== hdl/nlp_out_if.sv =====
// nlp_out_if: valid/ready channel carrying one parse result per item.
// Depends on nlp_pkg.
interface nlp_out_if import nlp_pkg::*; ();
  logic    valid;
  logic    ready;
  number_t number;
  radix_t  radix_kind;
  status_t status;

  modport source (output valid, output number, output radix_kind, output status,
                  input ready);
  modport sink   (input valid, input number, input radix_kind, input status,
                  output ready);
endinterface

// ===== hdl/numeric_literal_parser.sv =====
// numeric_literal_parser: ASCII hex/decimal/binary literal to 64-bit value.
// Depends on nlp_pkg, nlp_in_if and nlp_out_if.
//
//   channel   dir  payload                          item
//   in_ch     in   symbol[7:0], is_final            one character
//   out_ch    out  number[63:0], radix_kind, status one result per literal
//
// One item per cycle sustained unless a waiting result holds back a final
// character. An accepted character is registered in the input register and
// from there updates the parse state and, if final, loads the result register.
// Reset (synchronous, rst_n low) empties both stages and returns to the start
// of a literal. A waiting result holds back a final character in the input
// register, and the input with it; other characters keep flowing.
module numeric_literal_parser import nlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  nlp_in_if.sink    in_ch,
  nlp_out_if.source out_ch
);

  // input register
  logic    s1_valid_r;
  symbol_t s1_sym_r;
  logic    s1_fin_r;

  // parse state
  phase_t  phase_r, phase_nxt;
  number_t acc_r, acc_nxt;
  logic    ovf_r, ovf_nxt;

  // result register
  logic    out_valid_r;
  number_t out_number_r, out_number_nxt;
  radix_t  out_radix_r, out_radix_nxt;
  status_t out_status_r, out_status_nxt;

  logic       out_free;
  logic       s1_go;
  logic       in_take;
  digit_t     hx;
  logic       dec_ok;
  logic [NumberW+3:0] dec_sum;
  number_t    hex_acc;
  number_t    bin_acc;

  assign out_free = !out_valid_r || out_ch.ready;
  // a non-final character produces no result, so it never waits on the output
  assign s1_go    = s1_valid_r && (!s1_fin_r || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sym_r <= in_ch.symbol;
      s1_fin_r <= in_ch.is_final;
    end
  end

  assign hx      = hex_digit(s1_sym_r);
  assign dec_ok  = is_dec_digit(s1_sym_r);
  // acc * 10 + d as acc*8 + acc*2 + d; any bit above 63 means overflow
  assign dec_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {{(NumberW){1'b0}}, s1_sym_r[3:0]};
  assign hex_acc = {acc_r[NumberW-5:0], hx.value};
  assign bin_acc = {acc_r[NumberW-2:0], s1_sym_r[0]};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    unique case (phase_r)
      PH_START: begin
        if (s1_sym_r == CH_0) begin
          phase_nxt = PH_ZERO;
        end else if (dec_ok) begin
          phase_nxt = PH_DEC;
          acc_nxt   = {{(NumberW-4){1'b0}}, s1_sym_r[3:0]};
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_ZERO: begin
        if (s1_sym_r == CH_LO_X || s1_sym_r == CH_UP_X) begin
          phase_nxt = PH_HEX_EMPTY;
        end else if (s1_sym_r == CH_LO_B || s1_sym_r == CH_UP_B) begin
          phase_nxt = PH_BIN_EMPTY;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_DEC: begin
        if (!dec_ok) begin
          phase_nxt = PH_BAD;
        end else if (!ovf_r) begin
          if (dec_sum[NumberW+3:NumberW] != 4'd0) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = dec_sum[NumberW-1:0];
          end
        end
      end
      PH_HEX_EMPTY, PH_HEX: begin
        if (!hx.ok) begin
          phase_nxt = PH_BAD;
        end else begin
          phase_nxt = PH_HEX;
          if (!ovf_r) begin
            if (acc_r[NumberW-1:NumberW-4] != 4'd0) begin
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = hex_acc;
            end
          end
        end
      end
      PH_BIN_EMPTY, PH_BIN: begin
        if (s1_sym_r != CH_0 && s1_sym_r != CH_1) begin
          phase_nxt = PH_BAD;
        end else begin
          phase_nxt = PH_BIN;
          if (!ovf_r) begin
            if (acc_r[NumberW-1]) begin
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = bin_acc;
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_BAD;
      end
    endcase
  end

  always_comb begin
    out_number_nxt = '0;
    out_radix_nxt  = RADIX_DEC;
    out_status_nxt = ST_BAD;
    unique case (phase_nxt)
      PH_ZERO, PH_DEC: begin
        out_radix_nxt  = RADIX_DEC;
        out_status_nxt = ST_OK;
      end
      PH_HEX: begin
        out_radix_nxt  = RADIX_HEX;
        out_status_nxt = ST_OK;
      end
      PH_BIN: begin
        out_radix_nxt  = RADIX_BIN;
        out_status_nxt = ST_OK;
      end
      default: begin
        out_radix_nxt  = RADIX_DEC;
        out_status_nxt = ST_BAD;
      end
    endcase
    if (out_status_nxt == ST_OK) begin
      if (ovf_nxt) begin
        out_status_nxt = ST_OVERFLOW;
      end else begin
        out_number_nxt = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (s1_go) begin
      if (s1_fin_r) begin
        // literal done: back to the start for the next one
        phase_r <= PH_START;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_fin_r) begin
      out_number_r <= out_number_nxt;
      out_radix_r  <= out_radix_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.number     = out_number_r;
  assign out_ch.radix_kind = out_radix_r;
  assign out_ch.status     = out_status_r;

`ifndef ASSERT_OFF
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_fin_r) |=> out_valid_r)
    else $error("final character did not load a result");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_fin_r) |=> (phase_r == PH_START))
    else $error("parse state not restarted after a final character");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (acc_r == '0 && !ovf_r))
    else $error("accumulator or overflow flag left over at literal start");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_number_r == '0))
    else $error("non-zero number with a failing status");

  a_bad_is_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_BAD) |-> (out_radix_r == RADIX_DEC))
    else $error("malformed literal reported with a non-decimal radix");
`endif

endmodule
